/* hw/rtl/lseg_pkg.sv */
// Shared types, codes and arithmetic helpers of the LED strip effect generator.
package lseg_pkg;

  // Command codes carried in the func field of an input word.
  typedef enum logic [2:0] {
    FUNC_SET     = 3'd0,
    FUNC_FILL    = 3'd1,
    FUNC_RAINBOW = 3'd2,
    FUNC_BREATH  = 3'd3,
    FUNC_BATTERY = 3'd4
  } func_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BRIGHTNESS = 1'b0,
    REG_STRIP_LEN  = 1'b1
  } reg_e;

  // How the back end walks the strip for one queued command.
  typedef enum logic [1:0] {
    KIND_SINGLE  = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_RAINBOW = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SETUP = 2'd1,
    BK_RUN   = 2'd2
  } back_state_e;

  localparam int unsigned QueueDepth = 2;
  localparam logic [7:0]  FullScale  = 8'd255;
  localparam logic [6:0]  BattRedMax = 7'd20;
  localparam logic [6:0]  BattYelMax = 7'd50;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] pixel_sel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run_start;
    logic [6:0] run_length;
    logic [6:0] charge_pct;
  } in_word_t;

  typedef struct packed {
    logic [5:0] led_index;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic [7:0] blue_out;
    logic       last_of_frame;
  } out_word_t;

  // One classified command as it waits between front and back end.
  typedef struct packed {
    kind_e      kind;
    logic [6:0] total;    // number of pixel writes
    logic [5:0] pix;      // target LED of a single write
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pre_k;    // first scale factor, full scale when unused
    logic       refresh;  // flag the final write
    logic [7:0] start;    // first LED of a rainbow run
    logic [7:0] hue;      // rainbow base hue
  } desc_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // floor(x * k / 255) without a divider; exact for every 8-bit x and k.
  function automatic logic [7:0] scale8(input logic [7:0] x, input logic [7:0] k);
    logic [15:0] prod;
    logic [15:0] sum;
    prod = 16'(x) * 16'(k);
    sum  = prod + (prod >> 8) + 16'd1;
    return sum[15:8];
  endfunction

  // Six-sector hue wheel with sectors of 43 steps, the last sector of 41.
  function automatic rgb_t hue_to_rgb(input logic [7:0] hv);
    rgb_t       c;
    logic [7:0] base;
    logic [2:0] sector;
    logic [7:0] f;
    logic [7:0] q;
    if (hv >= 8'd215) begin
      sector = 3'd5; base = 8'd215;
    end else if (hv >= 8'd172) begin
      sector = 3'd4; base = 8'd172;
    end else if (hv >= 8'd129) begin
      sector = 3'd3; base = 8'd129;
    end else if (hv >= 8'd86) begin
      sector = 3'd2; base = 8'd86;
    end else if (hv >= 8'd43) begin
      sector = 3'd1; base = 8'd43;
    end else begin
      sector = 3'd0; base = 8'd0;
    end
    f = 8'((hv - base) * 8'd6);
    q = FullScale - f;
    case (sector)
      3'd0: c = '{red: FullScale, green: f, blue: 8'd0};
      3'd1: c = '{red: q, green: FullScale, blue: 8'd0};
      3'd2: c = '{red: 8'd0, green: FullScale, blue: f};
      3'd3: c = '{red: 8'd0, green: q, blue: FullScale};
      3'd4: c = '{red: f, green: 8'd0, blue: FullScale};
      default: c = '{red: FullScale, green: 8'd0, blue: q};
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/lseg_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module lseg_div #(
  parameter int unsigned DW = 9,
  parameter int unsigned VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quo_o,
  output logic [VW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(DW + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DW-1:0]   quo_q;
  logic [VW-1:0]   rem_q;
  logic [VW-1:0]   dvs_q;
  logic [VW:0]     trial;
  logic            fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(DW);
    end else if (busy_q) begin
      busy_q <= cnt_q != CntW'(1);
      cnt_q  <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

/* hw/rtl/lseg_front.sv */
// Command front end: accepts words, keeps effect state and classifies commands.
module lseg_front #(
  parameter int unsigned LED_CAP = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lseg_pkg::in_word_t in_word_i,
  input  logic [6:0]        strip_n_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lseg_pkg::desc_t   desc_o
);
  import lseg_pkg::*;

  localparam logic [6:0] MaxLeds = 7'(LED_CAP);

  logic       accept;
  logic       keep;
  logic [7:0] hue_q, hue_d;
  logic [7:0] level_q, level_d;
  logic       rising_q, rising_d;
  logic [6:0] len_sat;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept && keep;
  assign len_sat    = (in_word_i.run_length > MaxLeds) ? MaxLeds : in_word_i.run_length;

  // Breathing triangle: the stored level moves before it is used.
  always_comb begin
    if (rising_q) begin
      level_d  = level_q + 8'd1;
      rising_d = level_d != FullScale;
    end else begin
      level_d  = level_q - 8'd1;
      rising_d = level_d == 8'd0;
    end
  end

  always_comb begin
    hue_d          = hue_q;
    keep           = 1'b0;
    desc_o.kind    = KIND_FILL;
    desc_o.total   = strip_n_i;
    desc_o.pix     = in_word_i.pixel_sel[5:0];
    desc_o.red     = in_word_i.red;
    desc_o.green   = in_word_i.green;
    desc_o.blue    = in_word_i.blue;
    desc_o.pre_k   = FullScale;
    desc_o.refresh = 1'b0;
    desc_o.start   = in_word_i.run_start;
    desc_o.hue     = hue_q;
    case (in_word_i.func)
      FUNC_SET: begin
        keep         = in_word_i.pixel_sel < {1'b0, strip_n_i};
        desc_o.kind  = KIND_SINGLE;
        desc_o.total = 7'd1;
      end
      FUNC_FILL: begin
        keep = strip_n_i != 7'd0;
      end
      FUNC_RAINBOW: begin
        keep           = (strip_n_i != 7'd0) && (len_sat != 7'd0);
        desc_o.kind    = KIND_RAINBOW;
        desc_o.total   = len_sat;
        desc_o.refresh = 1'b1;
        hue_d          = hue_q + 8'd1;
      end
      FUNC_BREATH: begin
        keep           = strip_n_i != 7'd0;
        desc_o.pre_k   = level_d;
        desc_o.refresh = 1'b1;
      end
      FUNC_BATTERY: begin
        keep           = strip_n_i != 7'd0;
        desc_o.refresh = 1'b1;
        desc_o.blue    = 8'd0;
        if (in_word_i.charge_pct <= BattRedMax) begin
          desc_o.red   = FullScale;
          desc_o.green = 8'd0;
        end else if (in_word_i.charge_pct <= BattYelMax) begin
          desc_o.red   = FullScale;
          desc_o.green = FullScale;
        end else begin
          desc_o.red   = 8'd0;
          desc_o.green = FullScale;
        end
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q    <= 8'd0;
      level_q  <= 8'd0;
      rising_q <= 1'b1;
    end else if (accept) begin
      hue_q <= hue_d;
      if (in_word_i.func == FUNC_BREATH) begin
        level_q  <= level_d;
        rising_q <= rising_d;
      end
    end
  end
endmodule

/* hw/rtl/lseg_queue.sv */
// Two-entry command queue between front and back end.
module lseg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lseg_pkg::desc_t push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            not_empty_o,
  output lseg_pkg::desc_t pop_desc_o
);
  import lseg_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  desc_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o      = cnt_q == CntW'(QueueDepth);
  assign not_empty_o = cnt_q != '0;
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_desc_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> not_empty_o)
    else $error("command queue read while empty");
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("command queue count lost a push");
`endif
endmodule

/* hw/rtl/lseg_back.sv */
// Pixel back end: walks one command over the strip and scales each write.
module lseg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_not_empty_i,
  input  lseg_pkg::desc_t    q_desc_i,
  output logic               pop_o,
  input  logic [6:0]         strip_n_i,
  input  logic [7:0]         brightness_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lseg_pkg::out_word_t out_word_o
);
  import lseg_pkg::*;

  back_state_e state_q, state_d;
  desc_t       cmd_q;
  logic [6:0]  cnt_q;
  logic [5:0]  idx_q;
  logic [8:0]  hq_q;     // integer part of i*256/len
  logic [6:0]  hr_q;     // remainder part of i*256/len
  logic        div_start, gen_fire, last_step, div_busy;
  logic [8:0]  step_quo;
  logic [6:0]  step_rem, start_rem;
  logic [7:0]  rsum;
  logic [6:0]  idx_inc;
  rgb_t        gen_rgb;

  // Pipeline: S1 color, S2 first scaling, S3 brightness and output register.
  logic       s1_v_q, s2_v_q, s3_v_q;
  logic       s1_rdy, s2_rdy, s3_rdy;
  logic [5:0] s1_idx_q, s2_idx_q;
  rgb_t       s1_rgb_q, s2_rgb_q;
  logic [7:0] s1_k_q;
  logic       s1_last_q, s2_last_q;
  out_word_t  s3_word_q;

  lseg_div #(.DW(9), .VW(7)) u_step_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (9'd256),
    .divisor_i  (q_desc_i.total),
    .busy_o     (div_busy),
    .quo_o      (step_quo),
    .rem_o      (step_rem)
  );

  lseg_div #(.DW(9), .VW(7)) u_start_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({1'b0, q_desc_i.start}),
    .divisor_i  (strip_n_i),
    .busy_o     (),
    .quo_o      (),
    .rem_o      (start_rem)
  );

  assign s3_rdy = !s3_v_q || !out_stall_i;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;

  assign last_step = (cnt_q + 7'd1) == cmd_q.total;
  assign idx_inc   = {1'b0, idx_q} + 7'd1;
  assign rsum      = {1'b0, hr_q} + {1'b0, step_rem};
  assign gen_rgb   = (cmd_q.kind == KIND_RAINBOW) ? hue_to_rgb(cmd_q.hue + hq_q[7:0])
                     : rgb_t'{red: cmd_q.red, green: cmd_q.green, blue: cmd_q.blue};

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_not_empty_i) begin
          state_d = (q_desc_i.kind == KIND_RAINBOW) ? BK_SETUP : BK_RUN;
        end
      end
      BK_SETUP: begin
        if (!div_busy) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (s1_rdy && last_step) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    gen_fire  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        pop_o     = q_not_empty_i;
        div_start = q_not_empty_i && (q_desc_i.kind == KIND_RAINBOW);
      end
      BK_RUN:  gen_fire = s1_rdy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (s1_rdy) s1_v_q <= gen_fire;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
    end
  end

  // Walk state of the current command.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_desc_i;
      cnt_q <= 7'd0;
      idx_q <= (q_desc_i.kind == KIND_SINGLE) ? q_desc_i.pix : 6'd0;
      hq_q  <= 9'd0;
      hr_q  <= 7'd0;
    end else if (state_q == BK_SETUP) begin
      idx_q <= start_rem[5:0];
    end else if (gen_fire) begin
      cnt_q <= cnt_q + 7'd1;
      idx_q <= (idx_inc == strip_n_i) ? 6'd0 : idx_inc[5:0];
      if (rsum >= {1'b0, cmd_q.total}) begin
        hr_q <= 7'(rsum - {1'b0, cmd_q.total});
        hq_q <= hq_q + step_quo + 9'd1;
      end else begin
        hr_q <= rsum[6:0];
        hq_q <= hq_q + step_quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && gen_fire) begin
      s1_idx_q  <= idx_q;
      s1_rgb_q  <= gen_rgb;
      s1_k_q    <= cmd_q.pre_k;
      s1_last_q <= cmd_q.refresh && last_step;
    end
    if (s2_rdy && s1_v_q) begin
      s2_idx_q       <= s1_idx_q;
      s2_rgb_q.red   <= scale8(s1_rgb_q.red, s1_k_q);
      s2_rgb_q.green <= scale8(s1_rgb_q.green, s1_k_q);
      s2_rgb_q.blue  <= scale8(s1_rgb_q.blue, s1_k_q);
      s2_last_q      <= s1_last_q;
    end
    if (s3_rdy && s2_v_q) begin
      s3_word_q.led_index     <= s2_idx_q;
      s3_word_q.red_out       <= scale8(s2_rgb_q.red, brightness_i);
      s3_word_q.green_out     <= scale8(s2_rgb_q.green, brightness_i);
      s3_word_q.blue_out      <= scale8(s2_rgb_q.blue, brightness_i);
      s3_word_q.last_of_frame <= s2_last_q;
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_word_o  = s3_word_q;

`ifndef ASSERT_OFF
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_fire |-> cnt_q < cmd_q.total)
    else $error("pixel walk ran past the end of its command");
  a_hue_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_fire && cmd_q.kind == KIND_RAINBOW) |-> hr_q < cmd_q.total)
    else $error("rainbow hue remainder out of range");
  a_led_in_strip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_word_o.led_index} < strip_n_i)
    else $error("write addresses an LED outside the strip");
  a_setup_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN && $past(state_q) == BK_SETUP) |-> !div_busy)
    else $error("rainbow walk started before its step was known");
`endif
endmodule

/* hw/rtl/led_strip_effect_generator.sv */
// Top level of the LED strip effect generator: configuration registers and units.
//
// Each command word expands into a run of pixel words, one per LED written,
// each carrying the LED number and its green, red and blue values scaled by
// the brightness register (floor(x*brightness/255)). Set pixel writes one
// LED (nothing if the index is outside the strip), fill writes every LED in
// use, and rainbow, breathing and battery commands write a whole run and
// flag its final word as a strip refresh. A front end accepts and classifies
// commands and keeps the rainbow hue and breathing level; a two-entry queue
// lets it take the next command while the back end still emits the current
// one. The back end emits at most one word per cycle and passes through
// an idle state between commands; before a rainbow run starts, a bit-serial
// divider finds the hue step and the first LED number. Words leave through
// a three-stage scaling pipeline with an output register, so a stalled
// output does not stall the input until the queue fills. Configuration is
// meant to change only while the block is idle; a strip length above
// LED_CAP acts as LED_CAP.
module led_strip_effect_generator #(
  parameter int unsigned LED_CAP = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lseg_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lseg_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  lseg_pkg::reg_e      cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import lseg_pkg::*;

  localparam logic [6:0] MaxLeds = 7'(LED_CAP);

  logic [7:0] brightness_q;
  logic [6:0] strip_len_q;
  logic [6:0] strip_n;
  logic       q_full, q_push, q_pop, q_not_empty;
  desc_t      push_desc, pop_desc;

  // Register writes take effect at once; there is no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= 8'd255;
      strip_len_q  <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BRIGHTNESS: brightness_q <= cfg_data_i;
        REG_STRIP_LEN:  strip_len_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Number of LEDs actually driven.
  assign strip_n = (strip_len_q > MaxLeds) ? MaxLeds : strip_len_q;

  lseg_front #(.LED_CAP(LED_CAP)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .strip_n_i  (strip_n),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .desc_o     (push_desc)
  );

  lseg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_desc_o  (pop_desc)
  );

  lseg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_desc_i      (pop_desc),
    .pop_o         (q_pop),
    .strip_n_i     (strip_n),
    .brightness_i  (brightness_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

`ifndef ASSERT_OFF
  a_strip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strip_n <= MaxLeds)
    else $error("strip size exceeds the LED capacity");
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> in_stall_o)
    else $error("input taken while the command queue is full");
  a_set_oob_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.func == FUNC_SET &&
     in_word_i.pixel_sel >= {1'b0, strip_n}) |-> !q_push)
    else $error("out-of-strip set pixel was queued");
`endif
endmodule
